@@ hw/rtl/ppd_pkg.sv @@
// Shared types, codes and defaults for the palette pixel doubler.
package ppd_pkg;

   localparam int MAX_SRC_WIDTH_DEF = 1024;
   localparam int MAX_SRC_ROWS_DEF  = 1024;
   localparam int PALETTE_SIZE_DEF  = 256;

   localparam int PIX_W  = 8;
   localparam int ROW_W  = 11;
   localparam int COL_W  = 11;
   localparam int MODE_W = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_SCALE_MODE = 1'b0;

   localparam logic [MODE_W-1:0] MODE_BLANK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DUP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INTERP = 2'd2;

   localparam logic REQ_TABLE = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREF,
      ST_EVEN,
      ST_ODD
   } ppd_state_type;

   typedef enum logic [1:0] {
      ODD_NONE,
      ODD_DUP,
      ODD_INTERP
   } ppd_odd_type;

   typedef struct packed {
      logic busy;
      logic buf_valid;
   } ppd_stat_type;

endpackage

@@ hw/rtl/ppd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ppd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ppd_csr.sv @@
// APB-style configuration register block (scale mode).
module ppd_csr
   import ppd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [MODE_W-1:0]     scale_mode
);

   logic [MODE_W-1:0] scale_mode_ff;
   logic [MODE_W-1:0] scale_mode_in;
   logic              hit;

   assign hit        = (csr_paddr[CSR_ADDR_W-1:2] == REG_SCALE_MODE);
   assign csr_pready = 1'b1;

   always_comb begin
      scale_mode_in = scale_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         scale_mode_in = csr_pwdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff <= MODE_BLANK;
      end else begin
         scale_mode_ff <= scale_mode_in;
      end
   end

   assign csr_prdata = hit ? CSR_DATA_W'(scale_mode_ff) : '0;
   assign scale_mode = scale_mode_ff;

endmodule

@@ hw/rtl/ppd_seq.sv @@
// Sequencer: input buffer, blend table and prior line RAMs, result register.
module ppd_seq
   import ppd_pkg::*;
#(
   parameter int MAX_SRC_WIDTH = MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_ROWS  = MAX_SRC_ROWS_DEF,
   parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] scale_mode,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [PIX_W-1:0]  req_blend_first,
   input  logic [PIX_W-1:0]  req_blend_second,
   input  logic [PIX_W-1:0]  req_blend_value,
   input  logic [PIX_W-1:0]  req_pixel,
   input  logic              req_row_end,
   input  logic              req_frame_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_out_row,
   output logic [COL_W-1:0]  rsp_out_col,
   output logic [PIX_W-1:0]  rsp_out_value,
   output logic              rsp_run_last,
   output ppd_stat_type      stat
);

   localparam int CW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int RW = (MAX_SRC_ROWS > 1) ? $clog2(MAX_SRC_ROWS) : 1;
   localparam int PW = CW + 1;
   localparam int BT_DEPTH = PALETTE_SIZE * PALETTE_SIZE;
   localparam int PL_DEPTH = 2 * MAX_SRC_WIDTH;
   localparam int BW = $clog2(BT_DEPTH);
   localparam int LW = $clog2(PL_DEPTH);

   function automatic logic [PIX_W-1:0] pal_clamp(input logic [PIX_W-1:0] v);
      if (int'(v) < PALETTE_SIZE) begin
         return v;
      end
      return PIX_W'(PALETTE_SIZE - 1);
   endfunction

   function automatic logic [BW-1:0] tbl_addr(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      return BW'(int'(a) * PALETTE_SIZE + int'(b));
   endfunction

   function automatic logic [BW-1:0] blend_addr(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      return tbl_addr(pal_clamp(a), pal_clamp(b));
   endfunction

   // input buffer
   logic             buf_valid_ff, buf_valid_in;
   logic             buf_type_ff, buf_type_in;
   logic [PIX_W-1:0] buf_first_ff, buf_first_in;
   logic [PIX_W-1:0] buf_second_ff, buf_second_in;
   logic [PIX_W-1:0] buf_value_ff, buf_value_in;
   logic [PIX_W-1:0] buf_pixel_ff, buf_pixel_in;
   logic             buf_re_ff, buf_re_in;
   logic             buf_fe_ff, buf_fe_in;

   // stream state
   logic [PIX_W-1:0] held_ff, held_in;
   logic             have_held_ff, have_held_in;
   logic [CW-1:0]    col_cnt_ff, col_cnt_in;
   logic [RW-1:0]    row_cnt_ff, row_cnt_in;

   // per-transaction work registers
   ppd_state_type    state_ff, state_in;
   ppd_odd_type      odd_ff, odd_in;
   logic [1:0]       idx_ff, idx_in;
   logic [1:0]       last_idx_ff, last_idx_in;
   logic             pend_ff, pend_in;
   logic             cap_ff, cap_in;
   logic [ROW_W-1:0] erow_ff, erow_in;
   logic [ROW_W-1:0] orow_ff, orow_in;
   logic [COL_W-1:0] wcol_ff [4];
   logic [COL_W-1:0] wcol_in [4];
   logic [PIX_W-1:0] wval_ff [4];
   logic [PIX_W-1:0] wval_in [4];
   logic [PIX_W-1:0] pri_ff [4];
   logic [PIX_W-1:0] pri_in [4];

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [PIX_W-1:0] rsp_val_ff, rsp_val_in;
   logic             rsp_last_ff, rsp_last_in;

   // RAM ports
   logic             bt_wr_en, bt_rd_en;
   logic [BW-1:0]    bt_wr_addr, bt_rd_addr;
   logic [PIX_W-1:0] bt_wr_data, bt_rd_data;
   logic             pl_wr_en, pl_rd_en;
   logic [LW-1:0]    pl_wr_addr, pl_rd_addr;
   logic [PIX_W-1:0] pl_wr_data, pl_rd_data;

   logic             take, out_free, accept;
   logic [1:0]       nidx, rsel;
   logic [CW-1:0]    col_next, col_b;
   logic [RW-1:0]    row_next;
   logic [COL_W-1:0] base_a, base_a1, base_b, base_b1;
   logic [ROW_W-1:0] hrow;
   ppd_odd_type      odd_sel;

   ppd_ram #(
      .WIDTH(PIX_W),
      .DEPTH(BT_DEPTH)
   ) u_blend_ram (
      .clock  (clock),
      .wr_en  (bt_wr_en),
      .wr_addr(bt_wr_addr),
      .wr_data(bt_wr_data),
      .rd_en  (bt_rd_en),
      .rd_addr(bt_rd_addr),
      .rd_data(bt_rd_data)
   );

   ppd_ram #(
      .WIDTH(PIX_W),
      .DEPTH(PL_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (pl_wr_en),
      .wr_addr(pl_wr_addr),
      .wr_data(pl_wr_data),
      .rd_en  (pl_rd_en),
      .rd_addr(pl_rd_addr),
      .rd_data(pl_rd_data)
   );

   assign take      = buf_valid_ff && (state_ff == ST_IDLE);
   assign req_ready = !buf_valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign nidx      = idx_ff + 2'd1;
   assign rsel      = pend_ff ? nidx : idx_ff;

   assign col_next = (col_cnt_ff == CW'(MAX_SRC_WIDTH - 1)) ? '0 : col_cnt_ff + CW'(1);
   assign row_next = (row_cnt_ff == RW'(MAX_SRC_ROWS - 1)) ? '0 : row_cnt_ff + RW'(1);
   assign col_b    = have_held_ff ? col_next : col_cnt_ff;
   assign base_a   = COL_W'({col_cnt_ff, 1'b0});
   assign base_a1  = COL_W'({col_cnt_ff, 1'b1});
   assign base_b   = COL_W'({col_b, 1'b0});
   assign base_b1  = COL_W'({col_b, 1'b1});
   assign hrow     = ROW_W'({row_cnt_ff, 1'b0});

   always_comb begin
      unique case (scale_mode)
         MODE_DUP:    odd_sel = ODD_DUP;
         MODE_INTERP: odd_sel = (row_cnt_ff != '0) ? ODD_INTERP : ODD_NONE;
         default:     odd_sel = ODD_NONE;
      endcase
   end

   always_comb begin
      buf_valid_in  = accept || (buf_valid_ff && !take);
      buf_type_in   = buf_type_ff;
      buf_first_in  = buf_first_ff;
      buf_second_in = buf_second_ff;
      buf_value_in  = buf_value_ff;
      buf_pixel_in  = buf_pixel_ff;
      buf_re_in     = buf_re_ff;
      buf_fe_in     = buf_fe_ff;
      if (accept) begin
         buf_type_in   = req_type;
         buf_first_in  = req_blend_first;
         buf_second_in = req_blend_second;
         buf_value_in  = req_blend_value;
         buf_pixel_in  = req_pixel;
         buf_re_in     = req_row_end;
         buf_fe_in     = req_frame_end;
      end
   end

   always_comb begin
      state_in     = state_ff;
      odd_in       = odd_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      pend_in      = pend_ff;
      cap_in       = 1'b0;
      erow_in      = erow_ff;
      orow_in      = orow_ff;
      wcol_in      = wcol_ff;
      wval_in      = wval_ff;
      pri_in       = pri_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;

      bt_wr_en   = 1'b0;
      bt_wr_addr = tbl_addr(buf_first_ff, buf_second_ff);
      bt_wr_data = buf_value_ff;
      bt_rd_en   = 1'b0;
      bt_rd_addr = blend_addr(pri_ff[rsel], wval_ff[rsel]);
      pl_wr_en   = 1'b0;
      pl_wr_addr = LW'(wcol_ff[idx_ff][PW-1:0]);
      pl_wr_data = wval_ff[idx_ff];
      pl_rd_en   = 1'b0;
      pl_rd_addr = LW'(wcol_ff[nidx][PW-1:0]);

      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // blend of held pixel with its right neighbor lands in the cycle after start
      if (cap_ff) begin
         wval_in[1] = bt_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (buf_type_ff == REQ_TABLE) begin
                  bt_wr_en = (int'(buf_first_ff) < PALETTE_SIZE) &&
                             (int'(buf_second_ff) < PALETTE_SIZE);
               end else begin
                  if (have_held_ff) begin
                     wcol_in[0] = base_a;
                     wcol_in[1] = base_a1;
                     wcol_in[2] = base_b;
                     wcol_in[3] = base_b1;
                     wval_in[0] = held_ff;
                     wval_in[2] = buf_pixel_ff;
                     wval_in[3] = '0;
                  end else begin
                     wcol_in[0] = base_b;
                     wcol_in[1] = base_b1;
                     wval_in[0] = buf_pixel_ff;
                     wval_in[1] = '0;
                  end
                  cap_in      = have_held_ff;
                  bt_rd_en    = have_held_ff;
                  bt_rd_addr  = blend_addr(held_ff, buf_pixel_ff);
                  last_idx_in = (have_held_ff && buf_re_ff) ? 2'd3 : 2'd1;
                  odd_in      = odd_sel;
                  erow_in     = hrow;
                  orow_in     = (odd_sel == ODD_DUP) ? hrow + ROW_W'(1) : hrow - ROW_W'(1);
                  idx_in      = '0;
                  pend_in     = 1'b0;

                  if (buf_re_ff) begin
                     held_in      = '0;
                     have_held_in = 1'b0;
                     col_cnt_in   = '0;
                     row_cnt_in   = buf_fe_ff ? '0 : row_next;
                  end else begin
                     held_in      = buf_pixel_ff;
                     have_held_in = 1'b1;
                     col_cnt_in   = col_b;
                  end

                  if (have_held_ff || buf_re_ff) begin
                     if (odd_sel == ODD_INTERP) begin
                        pl_rd_en   = 1'b1;
                        pl_rd_addr = LW'(wcol_in[0][PW-1:0]);
                        state_in   = ST_PREF;
                     end else begin
                        state_in = ST_EVEN;
                     end
                  end
               end
            end
         end

         ST_PREF: begin
            // line values above, read before this transaction overwrites them
            pri_in[idx_ff] = pl_rd_data;
            if (idx_ff == last_idx_ff) begin
               idx_in   = '0;
               state_in = ST_EVEN;
            end else begin
               pl_rd_en = 1'b1;
               idx_in   = nidx;
            end
         end

         ST_EVEN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = erow_ff;
               rsp_col_in   = wcol_ff[idx_ff];
               rsp_val_in   = wval_ff[idx_ff];
               rsp_last_in  = (idx_ff == last_idx_ff) && (odd_ff == ODD_NONE);
               pl_wr_en     = 1'b1;
               if (idx_ff == last_idx_ff) begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = (odd_ff == ODD_NONE) ? ST_IDLE : ST_ODD;
               end else begin
                  idx_in = nidx;
               end
            end
         end

         ST_ODD: begin
            if (odd_ff == ODD_DUP) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = orow_ff;
                  rsp_col_in   = wcol_ff[idx_ff];
                  rsp_val_in   = wval_ff[idx_ff];
                  rsp_last_in  = (idx_ff == last_idx_ff);
                  if (idx_ff == last_idx_ff) begin
                     idx_in   = '0;
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = nidx;
                  end
               end
            end else if (!pend_ff) begin
               bt_rd_en = 1'b1;
               pend_in  = 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = orow_ff;
               rsp_col_in   = wcol_ff[idx_ff];
               rsp_val_in   = bt_rd_data;
               rsp_last_in  = (idx_ff == last_idx_ff);
               if (idx_ff == last_idx_ff) begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  bt_rd_en = 1'b1;
                  idx_in   = nidx;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         held_ff      <= '0;
         have_held_ff <= 1'b0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         held_ff      <= held_in;
         have_held_ff <= have_held_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_type_ff   <= buf_type_in;
      buf_first_ff  <= buf_first_in;
      buf_second_ff <= buf_second_in;
      buf_value_ff  <= buf_value_in;
      buf_pixel_ff  <= buf_pixel_in;
      buf_re_ff     <= buf_re_in;
      buf_fe_ff     <= buf_fe_in;
      odd_ff        <= odd_in;
      last_idx_ff   <= last_idx_in;
      erow_ff       <= erow_in;
      orow_ff       <= orow_in;
      wcol_ff       <= wcol_in;
      wval_ff       <= wval_in;
      pri_ff        <= pri_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_val_ff;
   assign rsp_run_last  = rsp_last_ff;

   assign stat.busy      = (state_ff != ST_IDLE);
   assign stat.buf_valid = buf_valid_ff;

endmodule

@@ hw/rtl/palette_pixel_doubler_2x.sv @@
// Top level of the 2x palette pixel doubler.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_type, blend fields, pixel, row/frame end
//   rsp      out  rsp_valid/rsp_ready    out_row, out_col, out_value, run_last
//   csr      in   APB psel/penable       scale_mode at byte address 0
//
// A pixel transaction with n even results (n = 0, 2 or 4) gives just those in modes 0
// and 3 and in mode 2 on source row 0; mode 1 adds n duplicated odd-row results, and
// mode 2 on later rows n blended ones; table writes and pixels without results give none.
// Throughput is set by the single result register (one result per cycle, rsp_ready
// permitting) and, in mode 2, by the prior line prefetch and the single blend read port.
// Synchronous active-high reset clears control and stream state; both RAMs are not cleared.
// A one-entry input buffer takes the next transaction while the current one runs;
// rsp_ready low with a result pending holds the sequencer wherever it issues a result.
module palette_pixel_doubler_2x
   import ppd_pkg::*;
#(
   parameter int MAX_SRC_WIDTH = MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_ROWS  = MAX_SRC_ROWS_DEF,
   parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [PIX_W-1:0]      req_blend_first,
   input  logic [PIX_W-1:0]      req_blend_second,
   input  logic [PIX_W-1:0]      req_blend_value,
   input  logic [PIX_W-1:0]      req_pixel,
   input  logic                  req_row_end,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic [PIX_W-1:0]      rsp_out_value,
   output logic                  rsp_run_last
);

   logic [MODE_W-1:0] scale_mode;
   ppd_stat_type      stat;

   ppd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .scale_mode (scale_mode)
   );

   ppd_seq #(
      .MAX_SRC_WIDTH(MAX_SRC_WIDTH),
      .MAX_SRC_ROWS (MAX_SRC_ROWS),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .scale_mode      (scale_mode),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_blend_first (req_blend_first),
      .req_blend_second(req_blend_second),
      .req_blend_value (req_blend_value),
      .req_pixel       (req_pixel),
      .req_row_end     (req_row_end),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_run_last    (rsp_run_last),
      .stat            (stat)
   );

`ifndef SYNTHESIS
   a_last_odd_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_out_col[0])
      else $error("last result of a transaction not on an odd column");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |-> stat.busy)
      else $error("sequencer idle with results of a transaction still pending");

   a_buf_loaded: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stat.buf_valid)
      else $error("accepted transaction not held in input buffer");
`endif

endmodule
